/* sv/tes_pkg.sv */
// tes_pkg: shared types, constants and helpers for the elision stripper
// no dependencies; imported by every module of the block
package tes_pkg;

    localparam int MAX_ARTICLE_CHARS = 3;
    localparam int ARTICLE_SLOTS     = 8;
    localparam int MAX_RESULTS       = MAX_ARTICLE_CHARS + 1;
    localparam int QDEPTH            = MAX_RESULTS + 1;
    localparam int CHAR_W            = 16;
    localparam int ARTICLE_W         = 50;
    localparam int LEN_LSB           = 48;

    localparam logic [CHAR_W-1:0] APOS_ASCII = 16'h0027;
    localparam logic [CHAR_W-1:0] APOS_RIGHT = 16'h2019;

    typedef logic [CHAR_W-1:0]    char_t;
    typedef logic [ARTICLE_W-1:0] article_t;
    typedef logic [1:0]           hcount_t;
    typedef logic [2:0]           rcount_t;
    typedef logic [2:0]           qcount_t;
    typedef logic [2:0]           slot_idx_t;
    typedef char_t [MAX_ARTICLE_CHARS-1:0] held_vec_t;

    typedef struct packed {
        char_t char_code;
        logic  token_end;
    } in_word_t;

    typedef struct packed {
        char_t out_char;
        logic  out_token_end;
        logic  empty_token;
    } out_word_t;

    typedef out_word_t [MAX_RESULTS-1:0] out_burst_t;

    // reset articles: l, m, t, qu, n, s, j, unused
    localparam article_t ARTICLE_RESET [ARTICLE_SLOTS] = '{
        50'h1_0000_0000_006C,
        50'h1_0000_0000_006D,
        50'h1_0000_0000_0074,
        50'h2_0000_0075_0071,
        50'h1_0000_0000_006E,
        50'h1_0000_0000_0073,
        50'h1_0000_0000_006A,
        50'h0_0000_0000_0000
    };

    // fold A-Z to lower case
    function automatic char_t fold_char(input char_t c);
        char_t r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            r = c + 16'h0020;
        end
        return r;
    endfunction

endpackage

/* sv/token_elision_stripper_core.sv */
// token_elision_stripper_core: top level of the elision stripper
// depends on tes_pkg, tes_slot_cell, tes_out_queue
//
//   port group | dir | handshake         | word
//   s_         | in  | s_valid / s_ready | in_word_t: char_code, token_end
//   m_         | out | m_valid / m_ready | out_word_t: out_char, out_token_end, empty_token
//   cfg_       | in  | cfg_we            | cfg_index selects article slot, cfg_wdata
//
// one input word per cycle while results flow one per cycle; a word is taken at the
// edge where s_valid and s_ready are high, and any results it yields join the output queue behind earlier ones
// a flush (up to four results from one word) holds s_ready low until the
// five-entry output queue drains back to one word
// s_ready depends only on the queue fill, never on m_ready in the same cycle
// synchronous active-low reset restores the default articles and empties the queue
module token_elision_stripper_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tes_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tes_pkg::out_word_t m_data,
    input  logic               cfg_we,
    input  tes_pkg::slot_idx_t cfg_index,
    input  tes_pkg::article_t  cfg_wdata
);
    import tes_pkg::*;

    held_vec_t  held_reg;
    held_vec_t  held_next;
    hcount_t    hc_reg;
    hcount_t    hc_next;
    logic       passing_reg;
    logic       passing_next;

    logic       s_accept;
    logic       pop;
    qcount_t    q_count;
    rcount_t    push_count;
    out_burst_t burst;
    out_burst_t flush_words;
    logic       hit_chain [ARTICLE_SLOTS+1];
    logic       is_apos;
    char_t      c;
    logic       e;

    // match chain of article slot cells
    assign hit_chain[0] = 1'b0;

    for (genvar s = 0; s < ARTICLE_SLOTS; s++) begin : g_slot
        tes_slot_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .wr_en      (cfg_we && cfg_index == slot_idx_t'(s)),
            .wr_data    (cfg_wdata),
            .reset_value(ARTICLE_RESET[s]),
            .held_chars (held_reg),
            .held_count (hc_reg),
            .hit_in     (hit_chain[s]),
            .hit_out    (hit_chain[s+1])
        );
    end

    // handshakes
    assign s_ready  = (q_count <= qcount_t'(QDEPTH - MAX_RESULTS));
    assign s_accept = s_valid && s_ready;
    assign m_valid  = (q_count != '0);
    assign pop      = m_valid && m_ready;

    assign c       = s_data.char_code;
    assign e       = s_data.token_end;
    assign is_apos = (c == APOS_ASCII) || (c == APOS_RIGHT);

    // held words then the current word, the last one carrying the input token end flag
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            flush_words[i].out_char      = c;
            flush_words[i].out_token_end = e;
            flush_words[i].empty_token   = 1'b0;
            if (i < MAX_ARTICLE_CHARS && 2'(i) < hc_reg) begin
                flush_words[i].out_char      = held_reg[i];
                flush_words[i].out_token_end = 1'b0;
            end
        end
    end

    // per-word decision
    always_comb begin
        held_next    = held_reg;
        hc_next      = hc_reg;
        passing_next = passing_reg;
        push_count   = '0;
        burst        = flush_words;
        if (s_accept) begin
            if (passing_reg) begin
                burst[0].out_char      = c;
                burst[0].out_token_end = e;
                burst[0].empty_token   = 1'b0;
                push_count   = rcount_t'(1);
                passing_next = !e;
            end else if (is_apos && hit_chain[ARTICLE_SLOTS]) begin
                hc_next = '0;
                if (e) begin
                    burst[0].out_char      = '0;
                    burst[0].out_token_end = 1'b1;
                    burst[0].empty_token   = 1'b1;
                    push_count = rcount_t'(1);
                end else begin
                    passing_next = 1'b1;
                end
            end else if (is_apos || e) begin
                push_count   = rcount_t'(hc_reg) + rcount_t'(1);
                hc_next      = '0;
                passing_next = !e;
            end else if (hc_reg < hcount_t'(MAX_ARTICLE_CHARS)) begin
                held_next[hc_reg] = c;
                hc_next           = hc_reg + 2'd1;
            end else begin
                push_count   = rcount_t'(hc_reg) + rcount_t'(1);
                hc_next      = '0;
                passing_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg      <= '0;
            passing_reg <= 1'b0;
        end else begin
            hc_reg      <= hc_next;
            passing_reg <= passing_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

    // result queue
    tes_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_count(push_count),
        .push_words(burst),
        .pop       (pop),
        .head      (m_data),
        .count     (q_count)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= qcount_t'(QDEPTH))
        else $error("output queue overfilled");

    // a held prefix only exists while scanning
    a_held_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (hc_reg != 2'd0) |-> !passing_reg)
        else $error("held prefix while passing");

    // end of token leaves the block scanning with nothing held
    a_token_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.token_end) |=> (!passing_reg && hc_reg == 2'd0))
        else $error("state not cleared at token end");

    // an accepted word in passing mode yields exactly one result
    a_pass_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && passing_reg && !pop) |=> (q_count == $past(q_count) + qcount_t'(1)))
        else $error("passing word did not yield one result");

endmodule

/* sv/tes_slot_cell.sv */
// tes_slot_cell: one article slot; holds its register and matches the held prefix
// depends on tes_pkg; a row of these forms the match chain of the core
module tes_slot_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  tes_pkg::article_t  wr_data,
    input  tes_pkg::article_t  reset_value,
    input  tes_pkg::held_vec_t held_chars,
    input  tes_pkg::hcount_t   held_count,
    input  logic               hit_in,
    output logic               hit_out
);
    import tes_pkg::*;

    article_t article_reg;
    article_t article_next;
    logic     own_hit;
    hcount_t  len;

    // article register, written from the config port
    always_comb begin
        article_next = article_reg;
        if (wr_en) begin
            article_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            article_reg <= reset_value;
        end else begin
            article_reg <= article_next;
        end
    end

    // compare held prefix against this article, case folded
    assign len = article_reg[LEN_LSB +: 2];

    always_comb begin
        own_hit = (len == held_count) && (held_count != 2'd0);
        for (int i = 0; i < MAX_ARTICLE_CHARS; i++) begin
            if (2'(i) < len &&
                fold_char(article_reg[CHAR_W*i +: CHAR_W]) != fold_char(held_chars[i])) begin
                own_hit = 1'b0;
            end
        end
    end

    // hand the accumulated hit to the next cell
    assign hit_out = hit_in | own_hit;

endmodule

/* sv/tes_out_queue.sv */
// tes_out_queue: shift queue for result words, takes a burst of up to four per cycle
// depends on tes_pkg
module tes_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  tes_pkg::rcount_t    push_count,
    input  tes_pkg::out_burst_t push_words,
    input  logic                pop,
    output tes_pkg::out_word_t  head,
    output tes_pkg::qcount_t    count
);
    import tes_pkg::*;

    out_word_t q_reg  [QDEPTH];
    out_word_t q_next [QDEPTH];
    qcount_t   cnt_reg;
    qcount_t   cnt_next;
    qcount_t   cnt_after;
    logic [3:0] end_pos;
    qcount_t   offs;

    assign cnt_after = cnt_reg - qcount_t'(pop);
    assign end_pos   = {1'b0, cnt_after} + {1'b0, push_count};

    // shift down on pop, append the burst behind the survivors
    always_comb begin
        offs = '0;
        for (int k = 0; k < QDEPTH; k++) begin
            if (pop && k < QDEPTH - 1) begin
                q_next[k] = q_reg[k+1];
            end else begin
                q_next[k] = q_reg[k];
            end
            offs = qcount_t'(k) - cnt_after;
            if (qcount_t'(k) >= cnt_after && 4'(k) < end_pos) begin
                q_next[k] = push_words[offs[1:0]];
            end
        end
        cnt_next = end_pos[2:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < QDEPTH; k++) begin
            q_reg[k] <= q_next[k];
        end
    end

    assign head  = q_reg[0];
    assign count = cnt_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for the elision stripper top level
// needs tes_pkg and token_elision_stripper_core; drives tokens, predicts and checks results
module testbench;
    import tes_pkg::*;

    // scoreboard: predicts stripped words from accepted characters and checks them in order
    class stripper_scoreboard;
        article_t  articles [ARTICLE_SLOTS];
        char_t     held [MAX_ARTICLE_CHARS];
        int        held_n;
        bit        passing;
        out_word_t due_words [$];
        int        errors;
        int        chars_in;
        int        words_out;
        int        tokens;
        int        markers;

        function new();
            articles  = ARTICLE_RESET;
            held_n    = 0;
            passing   = 1'b0;
            errors    = 0;
            chars_in  = 0;
            words_out = 0;
            tokens    = 0;
            markers   = 0;
        endfunction

        function char_t lower(char_t c);
            return (c >= 16'h0041 && c <= 16'h005A) ? c + 16'h0020 : c;
        endfunction

        // held prefix equals one of the active articles, ignoring case
        function bit prefix_is_article();
            int len;
            bit same;
            if (held_n == 0) return 1'b0;
            for (int s = 0; s < ARTICLE_SLOTS; s++) begin
                len = int'(articles[s][LEN_LSB +: 2]);
                if (len != held_n) continue;
                same = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (lower(articles[s][16*i +: 16]) != lower(held[i])) same = 1'b0;
                end
                if (same) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void due(char_t c, bit last, bit empty);
            out_word_t w;
            w.out_char      = c;
            w.out_token_end = last;
            w.empty_token   = empty;
            due_words.push_back(w);
            if (empty) markers++;
        endfunction

        // held characters go out first, then c
        function void flush_held(char_t c, bit last);
            for (int i = 0; i < held_n; i++) due(held[i], 1'b0, 1'b0);
            due(c, last, 1'b0);
            held_n = 0;
        endfunction

        function void accept_char(in_word_t w);
            char_t c;
            bit    last;
            c    = w.char_code;
            last = w.token_end;
            chars_in++;
            if (last) tokens++;
            if (passing) begin
                due(c, last, 1'b0);
                if (last) passing = 1'b0;
            end else if (c == APOS_ASCII || c == APOS_RIGHT) begin
                if (prefix_is_article()) begin
                    held_n = 0;
                    if (last) due('0, 1'b1, 1'b1);
                    else passing = 1'b1;
                end else begin
                    flush_held(c, last);
                    passing = !last;
                end
            end else if (last) begin
                flush_held(c, 1'b1);
            end else if (held_n < MAX_ARTICLE_CHARS) begin
                held[held_n] = c;
                held_n++;
            end else begin
                // prefix too long for any article
                flush_held(c, 1'b0);
                passing = 1'b1;
            end
        endfunction

        function void report(string field, int want, int got);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_word(out_word_t got);
            out_word_t want;
            words_out++;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                return;
            end
            want = due_words.pop_front();
            // the character is don't-care on an empty-token marker
            if (!want.empty_token && got.out_char != want.out_char)
                report("out_char", want.out_char, got.out_char);
            if (got.out_token_end != want.out_token_end)
                report("out_token_end", want.out_token_end, got.out_token_end);
            if (got.empty_token != want.empty_token)
                report("empty_token", want.empty_token, got.empty_token);
        endfunction

        function void check_leftover();
            if (due_words.size() != 0) begin
                errors += due_words.size();
                $display("%0t: %0d words never arrived, expected %h, actual none",
                         $time, due_words.size(), due_words[0]);
            end
        endfunction
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_word_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_word_t m_data;
    logic      cfg_we    = 1'b0;
    slot_idx_t cfg_index = '0;
    article_t  cfg_wdata = '0;

    int    send_idle_pct  = 0;
    int    recv_idle_pct  = 0;
    bit    long_stall_req = 1'b0;
    int    stall_left     = 0;
    char_t token_buf [$];
    stripper_scoreboard sb = new();

    token_elision_stripper_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (long_stall_req) begin
            stall_left     = 80;
            long_stall_req = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_data);
    end

    function automatic char_t letter();
        char_t c;
        c = 16'h0061 + char_t'($urandom_range(25));
        if ($urandom_range(1) != 0) c = c - 16'h0020;
        return c;
    endfunction

    function automatic char_t any_char();
        if ($urandom_range(3) == 0) return char_t'($urandom);
        return letter();
    endfunction

    function automatic char_t apostrophe();
        return ($urandom_range(1) != 0) ? APOS_RIGHT : APOS_ASCII;
    endfunction

    function automatic char_t flip_case(char_t c);
        if ($urandom_range(1) == 0) return c;
        if (c >= 16'h0061 && c <= 16'h007A) return c - 16'h0020;
        if (c >= 16'h0041 && c <= 16'h005A) return c + 16'h0020;
        return c;
    endfunction

    // random article with garbage in lanes beyond its length
    function automatic article_t random_article();
        article_t a;
        a = article_t'({$urandom, $urandom});
        a[LEN_LSB +: 2] = 2'($urandom_range(3));
        for (int i = 0; i < MAX_ARTICLE_CHARS; i++) begin
            if ($urandom_range(2) != 0) a[16*i +: 16] = letter();
        end
        return a;
    endfunction

    function automatic void push_text(string t);
        for (int i = 0; i < t.len(); i++) token_buf.push_back(char_t'(t[i]));
    endfunction

    // build one random token, mostly article + apostrophe + tail
    function automatic void make_token();
        int       kind;
        int       len;
        article_t a;
        token_buf.delete();
        kind = $urandom_range(99);
        a    = sb.articles[$urandom_range(ARTICLE_SLOTS-1)];
        len  = int'(a[LEN_LSB +: 2]);
        if (kind < 75) begin
            for (int i = 0; i < len; i++) token_buf.push_back(flip_case(a[16*i +: 16]));
            // near miss: one char changed or one char too many
            if (kind >= 60) begin
                if (len > 0 && $urandom_range(1) != 0)
                    token_buf[$urandom_range(len-1)] = letter();
                else
                    token_buf.push_back(letter());
            end
            token_buf.push_back(apostrophe());
            len = $urandom_range(4);
            for (int i = 0; i < len; i++)
                token_buf.push_back(($urandom_range(7) == 0) ? apostrophe() : any_char());
        end else if (kind < 90) begin
            len = $urandom_range(1, 7);
            for (int i = 0; i < len; i++) token_buf.push_back(letter());
            if ($urandom_range(9) < 3) token_buf[$urandom_range(len-1)] = apostrophe();
        end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) token_buf.push_back(char_t'($urandom));
        end
    endfunction

    task automatic send_word(char_t c, bit last);
        in_word_t w;
        w.char_code = c;
        w.token_end = last;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.accept_char(w);
    endtask

    task automatic send_token();
        for (int i = 0; i < token_buf.size(); i++)
            send_word(token_buf[i], i == token_buf.size() - 1);
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait for every due word, then let the pipeline settle
    task automatic wait_drain();
        int guard;
        guard = 0;
        while (sb.due_words.size() != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_articles(input article_t set [ARTICLE_SLOTS]);
        for (int i = 0; i < ARTICLE_SLOTS; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= slot_idx_t'(i);
            cfg_wdata <= set[i];
            @(posedge aclk);
            sb.articles[i] = set[i];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int count, bit with_stall, bit with_pause);
        int  sent;
        bit  stalled;
        bit  paused;
        sent    = 0;
        stalled = 1'b0;
        paused  = 1'b0;
        while (sent < count) begin
            make_token();
            send_token();
            sent += token_buf.size();
            if (with_stall && !stalled && sent >= count / 3) begin
                long_stall_req = 1'b1;
                stalled        = 1'b1;
            end
            // sender holds back until the block has emptied
            if (with_pause && !paused && sent >= 2 * count / 3) begin
                idle_sender();
                while (sb.due_words.size() != 0) @(posedge aclk);
                paused = 1'b1;
            end
        end
        idle_sender();
        wait_drain();
    endtask

    // stimulus
    initial begin
        article_t edge_set [ARTICLE_SLOTS];
        article_t mixed_set [ARTICLE_SLOTS];

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed tokens on the default articles
        token_buf.delete(); push_text("l'a'");  send_token();
        token_buf = '{16'h004C, APOS_RIGHT};     send_token();
        token_buf.delete(); push_text("Qu'i");  send_token();
        token_buf.delete(); push_text("'");     send_token();
        token_buf.delete(); push_text("abc'd"); send_token();
        token_buf.delete(); push_text("wxyzA"); send_token();
        token_buf = '{16'hFFFF};                 send_token();
        token_buf = '{16'h0000, 16'hFFFF};       send_token();
        idle_sender();
        wait_drain();

        // extremes: all ones, unused, upper case, zero chars, apostrophe article
        edge_set = '{
            50'h3_FFFF_FFFF_FFFF,
            50'h0_0000_0000_0000,
            50'h1_0000_0000_0044,
            50'h2_0000_0055_0051,
            50'h3_0000_0000_0000,
            50'h3_0073_0075_006A,
            50'h1_ABCD_1234_0027,
            50'h2_0000_0041_005A
        };
        load_articles(edge_set);
        send_idle_pct = 6;
        recv_idle_pct = 84;
        run_random(135, 1'b1, 1'b1);

        for (int i = 0; i < ARTICLE_SLOTS; i++) mixed_set[i] = random_article();
        load_articles(mixed_set);
        send_idle_pct = 84;
        recv_idle_pct = 6;
        run_random(135, 1'b0, 1'b0);

        for (int i = 0; i < ARTICLE_SLOTS; i++) mixed_set[i] = random_article();
        load_articles(mixed_set);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(135, 1'b1, 1'b0);

        sb.check_leftover();
        $display("covered %0d characters in %0d tokens over four article sets",
                 sb.chars_in, sb.tokens);
        $display("checked %0d result words, %0d of them empty-token markers",
                 sb.words_out, sb.markers);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* token_elision_stripper_core.f */
sv/tes_pkg.sv
sv/tes_slot_cell.sv
sv/tes_out_queue.sv
sv/token_elision_stripper_core.sv
tb/testbench.sv
